[src/sula_pkg.sv]
`timescale 1ns / 1ps

package sula_pkg;

  // Item kinds
  localparam logic [2:0] REQ_MEM_WR  = 3'd0;
  localparam logic [2:0] REQ_PORT_WR = 3'd1;
  localparam logic [2:0] REQ_PORT_RD = 3'd2;
  localparam logic [2:0] REQ_KEY     = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;
  localparam logic [2:0] REQ_PIXEL   = 3'd5;

  // Display memory geometry
  localparam int          DISP_DEPTH = 6912;
  localparam int          DISP_AW    = 13;
  localparam logic [15:0] DISP_BASE  = 16'h4000;
  localparam logic [2:0]  ATTR_TOP   = 3'b110;   // attribute area starts at offset 0x1800

  // Keyboard and port constants
  localparam logic [4:0] KEY_ROW_IDLE = 5'h1F;
  localparam logic [2:0] KEY_FILL     = 3'b111;  // upper bits of a ULA port read
  localparam logic [7:0] IDLE_READ    = 8'hFF;
  localparam logic [2:0] KEY_BITS     = 3'd5;
  localparam logic [3:0] FLASH_LAST   = 4'd15;

  typedef struct packed {
    logic clr_write;
    logic accept;
    logic rd_bitmap;
    logic rd_attr;
    logic load_item;
    logic load_pixel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic req_pixel;
  } ctrl_stat_t;

  // Palette: bit 0 blue, bit 1 red, bit 2 green, bit 3 bright
  function automatic logic [31:0] palette(input logic [3:0] idx);
    logic [7:0] lvl;
    begin
      lvl = idx[3] ? 8'hFF : 8'hD7;
      palette = {8'hFF, (idx[1] ? lvl : 8'h00), (idx[2] ? lvl : 8'h00),
                 (idx[0] ? lvl : 8'h00)};
    end
  endfunction

endpackage

[src/sula_req_if.sv]
`timescale 1ns / 1ps

interface sula_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [15:0] addr;
  logic [7:0] data;
  logic [7:0] port_low;
  logic [7:0] high_byte;
  logic [2:0] key_row;
  logic [2:0] key_bit;
  logic       pressed;
  logic [7:0] pix_x;
  logic [7:0] pix_y;

  modport source (output valid, req_type, addr, data, port_low, high_byte, key_row,
                  key_bit, pressed, pix_x, pix_y, input ready);
  modport sink   (input valid, req_type, addr, data, port_low, high_byte, key_row,
                  key_bit, pressed, pix_x, pix_y, output ready);
endinterface

[src/sula_rsp_if.sv]
`timescale 1ns / 1ps

interface sula_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [3:0]  color_index;
  logic [31:0] argb;
  logic [2:0]  border;

  modport source (output valid, read_data, color_index, argb, border, input ready);
  modport sink   (input valid, read_data, color_index, argb, border, output ready);
endinterface

[src/sula_dp.sv]
`timescale 1ns / 1ps

module sula_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sula_pkg::ctrl_cmd_t   cmd,
  output sula_pkg::ctrl_stat_t  stat,
  input  logic [2:0]            req_type,
  input  logic [15:0]           addr,
  input  logic [7:0]            data,
  input  logic [7:0]            port_low,
  input  logic [7:0]            high_byte,
  input  logic [2:0]            key_row,
  input  logic [2:0]            key_bit,
  input  logic                  pressed,
  input  logic [7:0]            pix_x,
  input  logic [7:0]            pix_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_data,
  output logic [3:0]            color_index,
  output logic [31:0]           argb,
  output logic [2:0]            border
);

  logic [7:0] ram [sula_pkg::DISP_DEPTH];
  logic [7:0] mem_q;
  logic       rd_ok;

  logic [sula_pkg::DISP_AW-1:0] clr_addr;
  logic [sula_pkg::DISP_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]                   mem_wdata;
  logic                         mem_we, mem_re;

  logic [4:0] key_rows [8];
  logic [2:0] border_reg;
  logic [3:0] flash_count;
  logic       flash_phase;

  logic [7:0] lat_x, lat_y;
  logic [7:0] pix_byte;

  logic [15:0]                  wr_ofs16;
  logic                         wr_ok;
  logic [sula_pkg::DISP_AW-1:0] bm_off, at_off;
  logic                         bm_ok, at_ok;

  logic [4:0] key_acc;
  logic [7:0] item_read;
  logic [2:0] border_next;

  logic [7:0] attr;
  logic       pix_on;
  logic [2:0] ink, paper;
  logic [3:0] pix_ci;

  // Address decode
  assign wr_ofs16 = addr - sula_pkg::DISP_BASE;
  assign wr_ok    = (addr >= sula_pkg::DISP_BASE) &&
                    (wr_ofs16 < 16'(sula_pkg::DISP_DEPTH));
  assign bm_off   = {pix_y[7:6], pix_y[2:0], pix_y[5:3], pix_x[7:3]};
  assign bm_ok    = bm_off < sula_pkg::DISP_AW'(sula_pkg::DISP_DEPTH);
  assign at_off   = {sula_pkg::ATTR_TOP, lat_y[7:3], lat_x[7:3]};
  assign at_ok    = at_off < sula_pkg::DISP_AW'(sula_pkg::DISP_DEPTH);

  assign stat.clr_last  = clr_addr == sula_pkg::DISP_AW'(sula_pkg::DISP_DEPTH - 1);
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.req_pixel = req_type == sula_pkg::REQ_PIXEL;

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'h00;
    mem_re    = 1'b0;
    mem_raddr = bm_off;
    if (cmd.clr_write) begin
      mem_we = 1'b1;
    end else if (cmd.load_item && req_type == sula_pkg::REQ_MEM_WR && wr_ok) begin
      mem_we    = 1'b1;
      mem_waddr = wr_ofs16[sula_pkg::DISP_AW-1:0];
      mem_wdata = data;
    end
    if (cmd.rd_bitmap) begin
      mem_re = 1'b1;
    end else if (cmd.rd_attr) begin
      mem_re    = 1'b1;
      mem_raddr = at_off;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ram[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= ram[mem_raddr];
      rd_ok <= cmd.rd_bitmap ? bm_ok : at_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + sula_pkg::DISP_AW'(1);
    end
  end

  // Keyboard read: AND the selected rows
  always_comb begin
    key_acc = sula_pkg::KEY_ROW_IDLE;
    for (int r = 0; r < 8; r++) begin
      if (!high_byte[r]) begin
        key_acc = key_acc & key_rows[r];
      end
    end
  end

  assign item_read = (req_type == sula_pkg::REQ_PORT_RD && !port_low[0]) ?
                     {sula_pkg::KEY_FILL, key_acc} : sula_pkg::IDLE_READ;
  assign border_next = (req_type == sula_pkg::REQ_PORT_WR && !port_low[0]) ?
                       data[2:0] : border_reg;

  // Architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 8; r++) begin
        key_rows[r] <= sula_pkg::KEY_ROW_IDLE;
      end
      border_reg  <= 3'd0;
      flash_count <= 4'd0;
      flash_phase <= 1'b0;
    end else if (cmd.load_item) begin
      border_reg <= border_next;
      if (req_type == sula_pkg::REQ_KEY && key_bit < sula_pkg::KEY_BITS) begin
        key_rows[key_row][key_bit] <= !pressed;
      end
      if (req_type == sula_pkg::REQ_TICK) begin
        if (flash_count == sula_pkg::FLASH_LAST) begin
          flash_count <= 4'd0;
          flash_phase <= !flash_phase;
        end else begin
          flash_count <= flash_count + 4'd1;
        end
      end
    end
  end

  // Pixel path
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_x <= pix_x;
      lat_y <= pix_y;
    end
    if (cmd.rd_attr) begin
      pix_byte <= rd_ok ? mem_q : 8'h00;
    end
  end

  assign attr   = rd_ok ? mem_q : 8'h00;
  assign pix_on = pix_byte[3'd7 - lat_x[2:0]];

  always_comb begin
    if (attr[7] && flash_phase) begin
      ink   = attr[5:3];
      paper = attr[2:0];
    end else begin
      ink   = attr[2:0];
      paper = attr[5:3];
    end
    pix_ci = {attr[6], (pix_on ? ink : paper)};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_item || cmd.load_pixel) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      read_data   <= item_read;
      color_index <= 4'd0;
      argb        <= 32'd0;
      border      <= border_next;
    end else if (cmd.load_pixel) begin
      read_data   <= sula_pkg::IDLE_READ;
      color_index <= pix_ci;
      argb        <= sula_pkg::palette(pix_ci);
      border      <= border_reg;
    end
  end

endmodule

[src/sula_ctrl.sv]
`timescale 1ns / 1ps

module sula_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  sula_pkg::ctrl_stat_t  stat,
  output sula_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ATTR   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready  = stat.out_free;
        cmd.accept = req_valid && stat.out_free;
        if (cmd.accept) begin
          if (stat.req_pixel) begin
            cmd.rd_bitmap = 1'b1;
            state_next    = ST_ATTR;
          end else begin
            cmd.load_item = 1'b1;
          end
        end
      end
      ST_ATTR: begin
        cmd.rd_attr = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/spectrum_ula_video_keyboard_unit.sv]
`timescale 1ns / 1ps

// Display and keyboard side of a 48K home-computer ULA. Each transfer on req
// carries one item (memory write, port write, port read, key event, frame tick
// or pixel request) and produces exactly one transfer on rsp. Memory writes,
// port writes/reads, key events and frame ticks finish in the cycle they are
// taken, so they run at one item per cycle while rsp keeps up. A pixel request
// runs through the attribute and finish states: the single read port of the
// 6912-byte display memory fetches the bitmap byte, then the attribute byte,
// and the colour is formed as the result is loaded, with req.ready low until that load.
// rsp is a single registered output: req.ready is high only while that
// register is empty or is being drained in the same cycle, so a result that
// waits unread holds req closed. After reset the display memory is zeroed by
// a clearing pass over all 6912 bytes, one byte a cycle, during which req.ready
// stays low.

module spectrum_ula_video_keyboard_unit (
  input  logic        clk,
  input  logic        rst,
  sula_req_if.sink    req,
  sula_rsp_if.source  rsp
);

  sula_pkg::ctrl_cmd_t  cmd;
  sula_pkg::ctrl_stat_t stat;

  // Sequencer: clearing pass, item acceptance, pixel fetch order
  sula_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Display memory, keyboard matrix, border, flash timer and output register
  sula_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req.req_type),
    .addr        (req.addr),
    .data        (req.data),
    .port_low    (req.port_low),
    .high_byte   (req.high_byte),
    .key_row     (req.key_row),
    .key_bit     (req.key_bit),
    .pressed     (req.pressed),
    .pix_x       (req.pix_x),
    .pix_y       (req.pix_y),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .read_data   (rsp.read_data),
    .color_index (rsp.color_index),
    .argb        (rsp.argb),
    .border      (rsp.border)
  );

endmodule

[src/sula_chk.sv]
`timescale 1ns / 1ps

module sula_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  rsp_read_data,
  input logic [3:0]  rsp_color_index,
  input logic [31:0] rsp_argb
);

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp dropped while stalled");

  // The clearing pass keeps req closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("req open during clearing pass");

  // Every read value carries the fixed upper bits
  a_read_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_read_data[7:5] == 3'b111)
    else $error("read_data upper bits not set");

  // A result whose read value is not 0xFF never carries pixel colour
  a_read_no_pixel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_read_data != 8'hFF |-> rsp_color_index == 4'd0 && rsp_argb == 32'd0)
    else $error("port read carries pixel data");

  // A non-zero colour index comes with an opaque palette word
  a_argb_alpha: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_color_index != 4'd0 |-> rsp_argb[31:24] == 8'hFF)
    else $error("palette word missing alpha");

endmodule

bind spectrum_ula_video_keyboard_unit sula_chk u_sula_chk (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_read_data   (rsp.read_data),
  .rsp_color_index (rsp.color_index),
  .rsp_argb        (rsp.argb)
);
